### hdl/assert_macros.svh
// assertion macros shared by the elevator dispatcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define EGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/egd_pkg.sv
// package with types and constants of the elevator group dispatcher
package egd_pkg;

    localparam int CARS_DEF        = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FLOORS_DEF      = 16;

    localparam logic [3:0] TRIP_LIMIT_RST = 4'd5;
    localparam logic [3:0] FLOOR_RST      = 4'd1;
    localparam logic [3:0] TRIPS_MAX      = 4'd15;

    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;
    localparam logic signed [1:0] DIR_STOP = 2'sb00;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CALL   = 2'd1,
        CMD_PAUSE  = 2'd2,
        CMD_REPAIR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CAR,
        S_CMD,
        S_REPORT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       step_car;
        logic       apply_cmd;
        logic [2:0] car_sel;
        logic       last;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic paused;
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]        car_index;
        logic [3:0]        car_floor;
        logic              car_busy;
        logic              car_loaded;
        logic signed [1:0] car_direction;
        logic              car_faulty;
        logic [3:0]        car_trips;
        logic              last_car;
        logic [4:0]        queue_level;
        logic              call_dropped;
        logic              paused;
    } t_report;

endpackage

### hdl/egd_ifs.sv
// valid/ready channel interfaces for dispatcher items and car reports
interface egd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] call_start;
    logic [3:0] call_target;

    modport source (output valid, output command, output call_start, output call_target,
                    input ready);
    modport sink (input valid, input command, input call_start, input call_target,
                  output ready);
endinterface

interface egd_report_if;
    logic              valid;
    logic              ready;
    logic [2:0]        car_index;
    logic [3:0]        car_floor;
    logic              car_busy;
    logic              car_loaded;
    logic signed [1:0] car_direction;
    logic              car_faulty;
    logic [3:0]        car_trips;
    logic              last_car;
    logic [4:0]        queue_level;
    logic              call_dropped;
    logic              paused;

    modport source (output valid, output car_index, output car_floor, output car_busy,
                    output car_loaded, output car_direction, output car_faulty,
                    output car_trips, output last_car, output queue_level,
                    output call_dropped, output paused, input ready);
    modport sink (input valid, input car_index, input car_floor, input car_busy,
                  input car_loaded, input car_direction, input car_faulty,
                  input car_trips, input last_car, input queue_level,
                  input call_dropped, input paused, output ready);
endinterface

### hdl/egd_controller.sv
// sequencing state machine of the elevator dispatcher
module egd_controller #(
    parameter int CARS = egd_pkg::CARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  egd_pkg::t_dp_stat i_stat,
    output egd_pkg::t_dp_ctrl o_ctrl
);
    import egd_pkg::*;

    localparam int CAR_W = (CARS > 1) ? $clog2(CARS) : 1;
    localparam logic [CAR_W-1:0] LAST_CAR = CAR_W'(CARS - 1);

    t_state           r_state, n_state;
    logic [CAR_W-1:0] r_car, n_car;
    logic [CAR_W+2:0] w_car_ext;
    logic             w_last;

    assign w_car_ext = {3'b000, r_car};
    assign w_last    = (r_car == LAST_CAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_car   <= '0;
        end else begin
            r_state <= n_state;
            r_car   <= n_car;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_car            = r_car;
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_ctrl.capture   = 1'b0;
        o_ctrl.step_car  = 1'b0;
        o_ctrl.apply_cmd = 1'b0;
        o_ctrl.car_sel   = w_car_ext[2:0];
        o_ctrl.last      = w_last;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_car          = '0;
                    n_state        = i_stat.paused ? S_CMD : S_LOAD;
                end
            end
            S_LOAD: begin
                // queue head read settles
                n_state = S_CAR;
            end
            S_CAR: begin
                o_ctrl.step_car = 1'b1;
                if (w_last) begin
                    n_state = S_CMD;
                end else begin
                    n_car   = r_car + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_CMD: begin
                o_ctrl.apply_cmd = 1'b1;
                n_car            = '0;
                n_state          = S_REPORT;
            end
            S_REPORT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_car = r_car + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/egd_datapath.sv
// car state, call queue memory and per-car update unit of the dispatcher
module egd_datapath #(
    parameter int CARS        = egd_pkg::CARS_DEF,
    parameter int QUEUE_DEPTH = egd_pkg::QUEUE_DEPTH_DEF,
    parameter int FLOORS      = egd_pkg::FLOORS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic [3:0]        i_call_start,
    input  logic [3:0]        i_call_target,
    input  egd_pkg::t_dp_ctrl i_ctrl,
    output egd_pkg::t_dp_stat o_stat,
    output egd_pkg::t_report  o_report
);
    import egd_pkg::*;

    localparam int CAR_W = (CARS > 1) ? $clog2(CARS) : 1;
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL      = CW'(QUEUE_DEPTH);
    localparam logic [3:0]    TOP_FLOOR = 4'(FLOORS - 1);

    function automatic logic signed [1:0] dir_of(input logic [3:0] a, input logic [3:0] b);
        logic signed [1:0] d;
        if (a < b) begin
            d = DIR_UP;
        end else if (a > b) begin
            d = DIR_DOWN;
        end else begin
            d = DIR_STOP;
        end
        return d;
    endfunction

    function automatic logic [3:0] clamp_floor(input logic [3:0] f);
        return (f > TOP_FLOOR) ? TOP_FLOOR : f;
    endfunction

    logic [3:0]        r_trip_limit;
    logic [3:0]        r_floor   [CARS];
    logic              r_busy    [CARS];
    logic              r_loaded  [CARS];
    logic signed [1:0] r_dir     [CARS];
    logic [3:0]        r_trips   [CARS];
    logic              r_fault   [CARS];
    logic [3:0]        r_pickup  [CARS];
    logic [3:0]        r_dest    [CARS];

    logic [7:0]        r_mem [QUEUE_DEPTH];
    logic [7:0]        r_rd;
    logic [QW-1:0]     r_head, r_tail;
    logic [CW-1:0]     r_count;
    logic              r_pause;
    logic              r_dropped;

    t_cmd              r_cmd;
    logic [3:0]        r_start, r_target;

    logic [CAR_W-1:0]  w_sel;
    logic              w_assign, w_full, w_push;
    logic [QW-1:0]     n_head, n_tail;
    logic [3:0]        n_floor, n_trips, n_pickup, n_dest;
    logic              n_busy, n_loaded, n_fault;
    logic signed [1:0] n_dir;
    logic [CW+4:0]     w_level_ext;

    assign w_sel  = i_ctrl.car_sel[CAR_W-1:0];
    assign w_full = (r_count == FULL);
    assign w_push = i_ctrl.apply_cmd && !r_pause && (r_cmd == CMD_CALL) && !w_full;
    assign n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;

    // assignment from the queue head, then one move for the selected car
    always_comb begin
        w_assign = (r_count != '0) && !r_busy[w_sel] && !r_fault[w_sel];
        n_pickup = w_assign ? r_rd[7:4] : r_pickup[w_sel];
        n_dest   = w_assign ? r_rd[3:0] : r_dest[w_sel];
        n_loaded = w_assign ? 1'b0 : r_loaded[w_sel];
        n_busy   = r_busy[w_sel] | w_assign;
        n_floor  = r_floor[w_sel];
        n_dir    = r_dir[w_sel];
        n_trips  = r_trips[w_sel];
        n_fault  = r_fault[w_sel];
        if (n_busy) begin
            if (n_loaded) begin
                n_dir   = dir_of(n_pickup, n_dest);
                n_floor = r_floor[w_sel] + {{2{n_dir[1]}}, n_dir};
                if (n_floor == n_dest) begin
                    n_busy   = 1'b0;
                    n_loaded = 1'b0;
                    if (r_trips[w_sel] != TRIPS_MAX) begin
                        n_trips = r_trips[w_sel] + 1'b1;
                    end
                    if (n_trips == r_trip_limit) begin
                        n_fault = 1'b1;
                    end
                end
            end else begin
                n_dir   = dir_of(r_floor[w_sel], n_pickup);
                n_floor = r_floor[w_sel] + {{2{n_dir[1]}}, n_dir};
                if (n_floor == n_pickup) begin
                    n_loaded = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip_limit <= TRIP_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_trip_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CARS; c++) begin
                r_floor[c]  <= FLOOR_RST;
                r_busy[c]   <= 1'b0;
                r_loaded[c] <= 1'b0;
                r_dir[c]    <= DIR_STOP;
                r_trips[c]  <= '0;
                r_fault[c]  <= 1'b0;
            end
        end else if (i_ctrl.step_car) begin
            r_floor[w_sel]  <= n_floor;
            r_busy[w_sel]   <= n_busy;
            r_loaded[w_sel] <= n_loaded;
            r_dir[w_sel]    <= n_dir;
            r_trips[w_sel]  <= n_trips;
            r_fault[w_sel]  <= n_fault;
        end else if (i_ctrl.apply_cmd && !r_pause && (r_cmd == CMD_REPAIR)) begin
            for (int c = 0; c < CARS; c++) begin
                r_trips[c] <= '0;
                r_fault[c] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step_car) begin
            r_pickup[w_sel] <= n_pickup;
            r_dest[w_sel]   <= n_dest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd    <= t_cmd'(i_command);
            r_start  <= i_call_start;
            r_target <= i_call_target;
        end
    end

    // call queue memory, registered read at the head
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= {clamp_floor(r_start), clamp_floor(r_target)};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pause   <= 1'b0;
            r_dropped <= 1'b0;
        end else if (i_ctrl.step_car) begin
            if (w_assign) begin
                r_head  <= n_head;
                r_count <= r_count - 1'b1;
            end
        end else if (i_ctrl.apply_cmd) begin
            if (r_pause) begin
                r_dropped <= 1'b0;
                if (r_cmd == CMD_PAUSE) begin
                    r_pause <= 1'b0;
                end
            end else begin
                r_dropped <= (r_cmd == CMD_CALL) && w_full;
                case (r_cmd)
                    CMD_CALL: begin
                        if (!w_full) begin
                            r_tail  <= n_tail;
                            r_count <= r_count + 1'b1;
                        end
                    end
                    CMD_PAUSE: begin
                        r_pause <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_level_ext = {5'b00000, r_count};

    assign o_stat.paused          = r_pause;
    assign o_report.car_index     = i_ctrl.car_sel;
    assign o_report.car_floor     = r_floor[w_sel];
    assign o_report.car_busy      = r_busy[w_sel];
    assign o_report.car_loaded    = r_loaded[w_sel];
    assign o_report.car_direction = r_dir[w_sel];
    assign o_report.car_faulty    = r_fault[w_sel];
    assign o_report.car_trips     = r_trips[w_sel];
    assign o_report.last_car      = i_ctrl.last;
    assign o_report.queue_level   = w_level_ext[4:0];
    assign o_report.call_dropped  = r_dropped;
    assign o_report.paused        = r_pause;

endmodule

### hdl/elevator_group_dispatcher.sv
// top level of the elevator group dispatcher: controller, datapath and channel glue
// Each input item is one tick of a group of CARS elevator cars that share a FIFO of
// up to QUEUE_DEPTH hall calls, and each item returns CARS status items, car 0 first,
// the final one flagged by last_car. An item has a load and a car step per car, then
// the command and the reports; while paused only the command and the reports. The
// single per-car update unit needs a load state before each car state because the
// queue memory's read port is registered and the head entry has to settle again
// after a car took a call. Input ready is high only between items, and reports come
// straight from the car registers, so the next item is taken the cycle after the
// last report is accepted. trip_limit must be written with i_cfg_we and i_cfg_data
// only while no item is in progress; the block does not enforce this. Its reset
// value is 5. The call queue is a memory without a clearing pass: entries are only
// read after they were written, tracked by head, tail and count.
module elevator_group_dispatcher #(
    parameter int CARS        = egd_pkg::CARS_DEF,
    parameter int QUEUE_DEPTH = egd_pkg::QUEUE_DEPTH_DEF,
    parameter int FLOORS      = egd_pkg::FLOORS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_data,
    egd_item_if.sink     i_item,
    egd_report_if.source o_report
);
    import egd_pkg::*;

    `include "assert_macros.svh"

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    t_report  w_report;

    // sequencer: accept, per-car load and step, command, reports
    egd_controller #(
        .CARS (CARS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_report.valid),
        .i_out_ready (o_report.ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    // car registers, call queue and the shared car update
    egd_datapath #(
        .CARS        (CARS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FLOORS      (FLOORS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_item.command),
        .i_call_start  (i_item.call_start),
        .i_call_target (i_item.call_target),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_report      (w_report)
    );

    // report fields onto the output channel
    assign o_report.car_index     = w_report.car_index;
    assign o_report.car_floor     = w_report.car_floor;
    assign o_report.car_busy      = w_report.car_busy;
    assign o_report.car_loaded    = w_report.car_loaded;
    assign o_report.car_direction = w_report.car_direction;
    assign o_report.car_faulty    = w_report.car_faulty;
    assign o_report.car_trips     = w_report.car_trips;
    assign o_report.last_car      = w_report.last_car;
    assign o_report.queue_level   = w_report.queue_level;
    assign o_report.call_dropped  = w_report.call_dropped;
    assign o_report.paused        = w_report.paused;

    // no new item while reports of the previous one are pending
    `EGD_ASSERT_IMPL(a_ready_vs_report, i_clk, i_rst_n, i_item.ready, !o_report.valid)
    // an accepted item starts work and closes the input
    `EGD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
    // handing over the final car report reopens the input
    `EGD_ASSERT_NEXT(a_last_reopens, i_clk, i_rst_n, o_report.valid && o_report.ready && o_report.last_car, i_item.ready)

endmodule

### tb/tb_elevator_group_dispatcher.sv
`timescale 1ns / 100ps
// self-checking testbench for the elevator group dispatcher
module tb_elevator_group_dispatcher;
    import egd_pkg::*;

    localparam int CARS        = CARS_DEF;
    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int FLOORS      = FLOORS_DEF;
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 31;

    // one row of the directed part; level, drop and paused are typed in where obvious
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] start;
        logic [3:0] target;
        bit         typed;
        logic [4:0] level;
        bit         drop;
        bit         paused;
    } t_row;

    // one random phase: trip limit, share of hall calls, idling on or off, long hold
    typedef struct packed {
        logic [3:0] limit;
        int         call_pct;
        bit         idling;
        bit         hold;
    } t_phase;

    // trip limit 1 is written first: three calls with pickup equal to destination
    // fault every car, the queue then fills up and the next call is dropped
    localparam t_row DIRECTED [28] = '{
        '{CMD_TICK,   4'd0,  4'd0,  1'b1, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd1,  4'd1,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd1,  4'd1,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd1,  4'd1,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_TICK,   4'd0,  4'd0,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_TICK,   4'd0,  4'd0,  1'b1, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd0,  4'd15, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd15, 4'd0,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd0,  4'd0,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd15, 4'd15, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd10, 4'd5,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd5,  4'd10, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd3,  4'd12, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd12, 4'd3,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd7,  4'd8,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd8,  4'd7,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd6,  4'd9,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd9,  4'd6,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd14, 4'd1,  1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd1,  4'd14, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd2,  4'd13, 1'b0, 5'd0,  1'b0, 1'b0},
        '{CMD_CALL,   4'd13, 4'd2,  1'b1, 5'd16, 1'b0, 1'b0},
        '{CMD_CALL,   4'd4,  4'd11, 1'b1, 5'd16, 1'b1, 1'b0},
        '{CMD_PAUSE,  4'd0,  4'd0,  1'b1, 5'd16, 1'b0, 1'b1},
        '{CMD_CALL,   4'd11, 4'd4,  1'b1, 5'd16, 1'b0, 1'b1},
        '{CMD_PAUSE,  4'd0,  4'd0,  1'b1, 5'd16, 1'b0, 1'b0},
        '{CMD_REPAIR, 4'd0,  4'd0,  1'b1, 5'd16, 1'b0, 1'b0},
        '{CMD_TICK,   4'd0,  4'd0,  1'b1, 5'd13, 1'b0, 1'b0}
    };

    localparam t_phase PHASES [6] = '{
        '{4'd15, 60, 1'b0, 1'b0},
        '{4'd1,  25, 1'b1, 1'b0},
        '{4'd4,  45, 1'b1, 1'b1},
        '{4'd9,  35, 1'b0, 1'b0},
        '{4'd2,  50, 1'b1, 1'b0},
        '{4'd15, 30, 1'b1, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;

    egd_item_if   item_ch ();
    egd_report_if status_ch ();

    elevator_group_dispatcher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_report   (status_ch)
    );

    // predicted state of the car group
    logic [3:0]        cabin_floor  [CARS];
    bit                cabin_busy   [CARS];
    bit                cabin_loaded [CARS];
    logic signed [1:0] cabin_dir    [CARS];
    logic [3:0]        cabin_pickup [CARS];
    logic [3:0]        cabin_dest   [CARS];
    logic [3:0]        cabin_trips  [CARS];
    bit                cabin_fault  [CARS];
    logic [3:0]        hall_start   [QDEPTH];
    logic [3:0]        hall_target  [QDEPTH];
    int                hall_head;
    int                hall_tail;
    int                hall_waiting;
    bit                halted;
    logic [3:0]        limit_now;

    // status items of the latest input item, and all status items still due
    t_report fresh_status [CARS];
    t_report status_due [$];

    int  mismatches;
    int  reports_seen;
    int  items_sent;
    int  calls_dropped;
    int  cycle_count;
    bit  idling;
    bit  long_hold_req;
    int  long_holds;

    // clock and cycle count
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run timed out after %0d cycles, %0d status items outstanding",
                 cycle_count, status_due.size());
        $display("FAIL");
        $finish;
    end

    // one step of a car: up, down or stay
    function automatic int toward(logic [3:0] from_floor, logic [3:0] to_floor);
        if (from_floor < to_floor) return 1;
        if (from_floor > to_floor) return -1;
        return 0;
    endfunction

    // advance the car group by one item and build its status items
    task automatic advance_group(t_cmd cmd, logic [3:0] start, logic [3:0] target);
        int c;
        int d;
        bit lost;
        lost = 1'b0;
        if (halted) begin
            // while halted only a pause command acts, and it resumes without a tick
            if (cmd == CMD_PAUSE) halted = 1'b0;
        end else begin
            // oldest calls go to idle healthy cars in car order
            for (c = 0; c < CARS; c++) begin
                if (hall_waiting > 0 && !cabin_busy[c] && !cabin_fault[c]) begin
                    cabin_pickup[c] = hall_start[hall_head];
                    cabin_dest[c]   = hall_target[hall_head];
                    hall_head       = (hall_head + 1) % QDEPTH;
                    hall_waiting--;
                    cabin_busy[c]   = 1'b1;
                    cabin_loaded[c] = 1'b0;
                end
            end
            // every busy car moves one floor, loads at pickup, arrives at destination
            for (c = 0; c < CARS; c++) begin
                if (cabin_busy[c]) begin
                    if (cabin_loaded[c]) begin
                        d = toward(cabin_pickup[c], cabin_dest[c]);
                        cabin_dir[c]   = 2'(d);
                        cabin_floor[c] = 4'(int'(cabin_floor[c]) + d);
                        if (cabin_floor[c] == cabin_dest[c]) begin
                            cabin_busy[c]   = 1'b0;
                            cabin_loaded[c] = 1'b0;
                            if (cabin_trips[c] < TRIPS_MAX) cabin_trips[c]++;
                            // exact match only, so a car past the limit keeps running
                            if (cabin_trips[c] == limit_now) cabin_fault[c] = 1'b1;
                        end
                    end else begin
                        d = toward(cabin_floor[c], cabin_pickup[c]);
                        cabin_dir[c]   = 2'(d);
                        cabin_floor[c] = 4'(int'(cabin_floor[c]) + d);
                        if (cabin_floor[c] == cabin_pickup[c]) cabin_loaded[c] = 1'b1;
                    end
                end
            end
            // the command takes effect after the tick
            case (cmd)
                CMD_CALL: begin
                    if (hall_waiting >= QDEPTH) begin
                        lost = 1'b1;
                    end else begin
                        hall_start[hall_tail]  = (start > FLOORS - 1) ? 4'(FLOORS - 1) : start;
                        hall_target[hall_tail] = (target > FLOORS - 1) ? 4'(FLOORS - 1) : target;
                        hall_tail = (hall_tail + 1) % QDEPTH;
                        hall_waiting++;
                    end
                end
                CMD_PAUSE: halted = 1'b1;
                CMD_REPAIR: begin
                    for (c = 0; c < CARS; c++) begin
                        cabin_fault[c] = 1'b0;
                        cabin_trips[c] = 4'd0;
                    end
                end
                default: ;
            endcase
        end
        if (lost) calls_dropped++;
        for (c = 0; c < CARS; c++) begin
            fresh_status[c].car_index     = 3'(c);
            fresh_status[c].car_floor     = cabin_floor[c];
            fresh_status[c].car_busy      = cabin_busy[c];
            fresh_status[c].car_loaded    = cabin_loaded[c];
            fresh_status[c].car_direction = cabin_dir[c];
            fresh_status[c].car_faulty    = cabin_fault[c];
            fresh_status[c].car_trips     = cabin_trips[c];
            fresh_status[c].last_car      = (c == CARS - 1);
            fresh_status[c].queue_level   = 5'(hall_waiting);
            fresh_status[c].call_dropped  = lost;
            fresh_status[c].paused        = halted;
        end
    endtask

    // offer one item, after a random gap when idling; on acceptance queue what it must produce
    task automatic send_item(t_cmd cmd, logic [3:0] start, logic [3:0] target,
                             bit typed, logic [4:0] level, bit drop, bit paused);
        int gap;
        int c;
        gap = idling ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.call_start  <= start;
        item_ch.call_target <= target;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        advance_group(cmd, start, target);
        for (c = 0; c < CARS; c++) begin
            if (typed) begin
                fresh_status[c].queue_level  = level;
                fresh_status[c].call_dropped = drop;
                fresh_status[c].paused       = paused;
            end
            status_due.push_back(fresh_status[c]);
        end
        items_sent++;
    endtask

    // drop valid and wait until every status item has come back
    task automatic drain_group();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    // trip limit is only written while the block is idle
    task automatic write_trip_limit(logic [3:0] value);
        drain_group();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_now = value;
    endtask

    task automatic note_mismatch(string field, int got, int want);
        $display("mismatch on status item %0d: %s is %0d, expected %0d",
                 reports_seen, field, got, want);
        mismatches++;
    endtask

    // compare one accepted status item with the oldest one due
    task automatic check_status(t_report got);
        t_report want;
        if (status_due.size() == 0) begin
            note_mismatch("unexpected status item, car", got.car_index, -1);
            return;
        end
        want = status_due.pop_front();
        if (got.car_index !== want.car_index)
            note_mismatch("car_index", got.car_index, want.car_index);
        if (got.car_floor !== want.car_floor)
            note_mismatch("car_floor", got.car_floor, want.car_floor);
        if (got.car_busy !== want.car_busy)
            note_mismatch("car_busy", got.car_busy, want.car_busy);
        if (got.car_loaded !== want.car_loaded)
            note_mismatch("car_loaded", got.car_loaded, want.car_loaded);
        if (got.car_direction !== want.car_direction)
            note_mismatch("car_direction", got.car_direction, want.car_direction);
        if (got.car_faulty !== want.car_faulty)
            note_mismatch("car_faulty", got.car_faulty, want.car_faulty);
        if (got.car_trips !== want.car_trips)
            note_mismatch("car_trips", got.car_trips, want.car_trips);
        if (got.last_car !== want.last_car)
            note_mismatch("last_car", got.last_car, want.last_car);
        if (got.queue_level !== want.queue_level)
            note_mismatch("queue_level", got.queue_level, want.queue_level);
        if (got.call_dropped !== want.call_dropped)
            note_mismatch("call_dropped", got.call_dropped, want.call_dropped);
        if (got.paused !== want.paused)
            note_mismatch("paused", got.paused, want.paused);
    endtask

    // status items are taken at the rising edge
    always @(posedge i_clk) begin
        t_report got;
        if (i_rst_n === 1'b1 && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
            got.car_index     = status_ch.car_index;
            got.car_floor     = status_ch.car_floor;
            got.car_busy      = status_ch.car_busy;
            got.car_loaded    = status_ch.car_loaded;
            got.car_direction = status_ch.car_direction;
            got.car_faulty    = status_ch.car_faulty;
            got.car_trips     = status_ch.car_trips;
            got.last_car      = status_ch.last_car;
            got.queue_level   = status_ch.queue_level;
            got.call_dropped  = status_ch.call_dropped;
            got.paused        = status_ch.paused;
            check_status(got);
            reports_seen++;
        end
    end

    // output side: random stalls per status item when idling, and one long hold on request
    initial begin : status_taker
        int stall;
        status_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                // long enough for the block to back up and stall its input
                stall = HOLD_CYCLES;
                long_hold_req = 1'b0;
                long_holds++;
            end else begin
                stall = idling ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                status_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            status_ch.ready <= 1'b1;
            do @(posedge i_clk); while (status_ch.valid !== 1'b1);
        end
    end

    // reset, directed items, then random phases
    initial begin : stimulus
        int   r;
        int   p;
        int   c;
        int   n;
        t_cmd cmd;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = 4'd0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_TICK;
        item_ch.call_start  = 4'd0;
        item_ch.call_target = 4'd0;
        mismatches    = 0;
        reports_seen  = 0;
        items_sent    = 0;
        calls_dropped = 0;
        long_holds    = 0;
        long_hold_req = 1'b0;
        idling        = 1'b1;

        // predicted state after reset
        for (c = 0; c < CARS; c++) begin
            cabin_floor[c]  = FLOOR_RST;
            cabin_busy[c]   = 1'b0;
            cabin_loaded[c] = 1'b0;
            cabin_dir[c]    = DIR_STOP;
            cabin_pickup[c] = 4'd0;
            cabin_dest[c]   = 4'd0;
            cabin_trips[c]  = 4'd0;
            cabin_fault[c]  = 1'b0;
        end
        hall_head    = 0;
        hall_tail    = 0;
        hall_waiting = 0;
        halted       = 1'b0;
        limit_now    = TRIP_LIMIT_RST;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: faults, full queue, drop, pause and repair
        write_trip_limit(4'd1);
        for (r = 0; r < $size(DIRECTED); r++) begin
            send_item(DIRECTED[r].cmd, DIRECTED[r].start, DIRECTED[r].target,
                      DIRECTED[r].typed, DIRECTED[r].level, DIRECTED[r].drop,
                      DIRECTED[r].paused);
        end

        // random part: mostly ticks and calls so cars run full trips
        for (p = 0; p < $size(PHASES); p++) begin
            write_trip_limit(PHASES[p].limit);
            idling = PHASES[p].idling;
            if (PHASES[p].hold) long_hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (halted) begin
                    // leave the pause soon, with some ignored items in between
                    cmd = (r < 40) ? CMD_PAUSE : t_cmd'($urandom_range(0, 3));
                end else if (r < PHASES[p].call_pct) begin
                    cmd = CMD_CALL;
                end else if (r < PHASES[p].call_pct + 5) begin
                    cmd = CMD_PAUSE;
                end else if (r < PHASES[p].call_pct + 11) begin
                    cmd = CMD_REPAIR;
                end else begin
                    cmd = CMD_TICK;
                end
                if (!halted || cmd == CMD_PAUSE) n++;
                send_item(cmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          1'b0, 5'd0, 1'b0, 1'b0);
            end
        end

        drain_group();
        repeat (30) @(posedge i_clk);
        if (status_due.size() != 0) note_mismatch("status items left over", status_due.size(), 0);

        $display("covered %0d items with %0d checked status items, %0d calls dropped",
                 items_sent, reports_seen, calls_dropped);
        $display("trip limits 1 to 15, pause and repair, %0d long output hold(s)", long_holds);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/egd_pkg.sv
hdl/egd_ifs.sv
hdl/egd_controller.sv
hdl/egd_datapath.sv
hdl/elevator_group_dispatcher.sv
tb/tb_elevator_group_dispatcher.sv
